@@ rtl/pse_pkg.sv @@
// process schedule evaluator: shared types, codes and field widths
// no dependencies; used by every module of the block except pse_div
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

	localparam int CFG_DW     = 16;
	localparam int BURST_IN_W = 16;
	localparam int PRI_W      = 8;
	localparam int QUANT_W    = 16;
	localparam int PNUM_W     = 7;
	localparam int TIME_W     = 22;
	localparam int AVG_W      = 30;
	localparam int FRAC_BITS  = 8;

	// configuration register indexes
	localparam logic REG_SCHED_MODE   = 1'b0;
	localparam logic REG_TIME_QUANTUM = 1'b1;

	typedef enum logic [1:0] {
		MODE_FCFS = 2'd0,
		MODE_SJF  = 2'd1,
		MODE_PRIO = 2'd2,
		MODE_RR   = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_SI_RD,
		OP_SI_CAP,
		OP_SJ_RD,
		OP_SJ_CMP,
		OP_SW1,
		OP_SW2,
		OP_RI_RD,
		OP_RI_WR,
		OP_RR_RD,
		OP_RR_EX,
		OP_EM_RD,
		OP_EM_EX,
		OP_DIVW_GO,
		OP_DIVW_WAIT,
		OP_DIVT_GO,
		OP_DIVT_WAIT,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  n_ge2;
		logic  j_last;
		logic  i_last;
		logic  i_end;
		logic  rr_more;
		logic  k_last;
		logic  div_done;
	} status_t;

endpackage
`default_nettype wire

@@ rtl/pse_div.sv @@
// process schedule evaluator: restoring divider, one quotient bit per cycle
// standalone; used by the datapath for the two averages
`timescale 1ns / 1ps
`default_nettype none
module pse_div #(
	parameter int DVW = 38,
	parameter int DSW = 7
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           go,
	input  wire logic [DVW-1:0] dividend,
	input  wire logic [DSW-1:0] divisor,
	output logic                done,
	output logic [DVW-1:0]      quotient
);

	localparam int STW = $clog2(DVW + 1);

	logic [DSW-1:0] rem_q;
	logic [DSW-1:0] dsr_q;
	logic [DVW-1:0] quo_q;
	logic [STW-1:0] step_q;
	logic           run_q;
	logic           done_q;
	logic [DSW:0]   shifted;
	logic           fits;

	assign shifted  = {rem_q, quo_q[DVW-1]};
	assign fits     = shifted >= {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= STW'(DVW);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= DSW'(shifted - {1'b0, dsr_q});
			end else begin
				rem_q <= shifted[DSW-1:0];
			end
			quo_q <= {quo_q[DVW-2:0], fits};
		end
	end

endmodule
`default_nettype wire

@@ rtl/pse_dp.sv @@
// process schedule evaluator: datapath with process memories, counters and results
// depends on pse_pkg and pse_div
`timescale 1ns / 1ps
`default_nettype none
module pse_dp #(
	parameter int MAX_PROCS  = 64,
	parameter int BURST_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic                             cfg_addr,
	input  wire logic [pse_pkg::CFG_DW-1:0]       cfg_wdata,
	input  wire logic [pse_pkg::BURST_IN_W-1:0]   burst_time,
	input  wire logic [pse_pkg::PRI_W-1:0]        priority_level,
	input  wire pse_pkg::cmd_t                    cmd,
	output pse_pkg::status_t                      status,
	output logic                                  result_valid,
	output logic [pse_pkg::PNUM_W-1:0]            process_number,
	output logic [pse_pkg::TIME_W-1:0]            waiting_time,
	output logic [pse_pkg::TIME_W-1:0]            turnaround_time,
	output logic [pse_pkg::AVG_W-1:0]             avg_waiting_fx,
	output logic [pse_pkg::AVG_W-1:0]             avg_turnaround_fx,
	output logic                                  last_result
);

	localparam int CNT_W = $clog2(MAX_PROCS + 1);
	localparam int AW    = $clog2(MAX_PROCS);
	localparam int PW    = pse_pkg::PRI_W;
	localparam int REC_W = CNT_W + PW + BURST_BITS;
	localparam int CLK_W = BURST_BITS + CNT_W;
	localparam int SUM_W = CLK_W + CNT_W;
	localparam int DVW   = SUM_W + pse_pkg::FRAC_BITS;
	localparam int QW    = (BURST_BITS > pse_pkg::QUANT_W) ? BURST_BITS : pse_pkg::QUANT_W;
	localparam int KW    = (BURST_BITS > PW) ? BURST_BITS : PW;

	// memories
	logic [REC_W-1:0]      rec_mem [MAX_PROCS];
	logic [BURST_BITS-1:0] rem_mem [MAX_PROCS];
	logic [CLK_W-1:0]      comp_mem [MAX_PROCS];

	logic [REC_W-1:0]      rec_rd_q;
	logic [BURST_BITS-1:0] rem_rd_q;
	logic [CLK_W-1:0]      comp_rd_q;

	pse_pkg::mode_t           mode_q;
	logic [pse_pkg::QUANT_W-1:0] quant_q;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	logic [AW-1:0]    best_q;
	logic [REC_W-1:0] reci_q;
	logic [REC_W-1:0] bestrec_q;
	logic [CLK_W-1:0] clock_q;
	logic [SUM_W-1:0] wsum_q;
	logic [SUM_W-1:0] tsum_q;
	logic             any_q;

	logic             valid_q;
	logic             last_q;
	logic [pse_pkg::PNUM_W-1:0] pnum_q;
	logic [pse_pkg::TIME_W-1:0] wt_q;
	logic [pse_pkg::TIME_W-1:0] tt_q;
	logic [pse_pkg::AVG_W-1:0]  aw_q;
	logic [pse_pkg::AVG_W-1:0]  at_q;

	// memory port selection
	logic             rec_we;
	logic [AW-1:0]    rec_waddr;
	logic [REC_W-1:0] rec_wdata;
	logic             rec_re;
	logic [AW-1:0]    rec_raddr;
	logic             rem_we;
	logic [BURST_BITS-1:0] rem_wdata;
	logic             comp_we;

	// rr step
	logic [BURST_BITS-1:0] r_cur;
	logic [QW-1:0]    q_eff;
	logic             r_gt_q;
	logic [CLK_W-1:0] rr_clock_nxt;

	// emission
	logic [BURST_BITS-1:0] em_burst;
	logic [CLK_W-1:0] em_w;
	logic [CLK_W-1:0] em_t;

	// sort compare
	logic [KW-1:0] key_new;
	logic [KW-1:0] key_best;

	logic           div_go;
	logic [DVW-1:0] div_dividend;
	logic           div_done;
	logic [DVW-1:0] div_quo;

	logic load_ok;

	assign load_ok = cnt_q < CNT_W'(MAX_PROCS);

	assign r_cur  = rem_rd_q;
	assign q_eff  = (quant_q == '0) ? QW'(1) : QW'(quant_q);
	assign r_gt_q = QW'(r_cur) > q_eff;
	assign rr_clock_nxt = clock_q + (r_gt_q ? CLK_W'(q_eff) : CLK_W'(r_cur));

	assign key_new  = (mode_q == pse_pkg::MODE_PRIO) ? KW'(rec_rd_q[BURST_BITS +: PW])
	                                                 : KW'(rec_rd_q[BURST_BITS-1:0]);
	assign key_best = (mode_q == pse_pkg::MODE_PRIO) ? KW'(bestrec_q[BURST_BITS +: PW])
	                                                 : KW'(bestrec_q[BURST_BITS-1:0]);

	assign em_burst = rec_rd_q[BURST_BITS-1:0];

	always_comb begin
		if (mode_q == pse_pkg::MODE_RR) begin
			if (em_burst == '0) begin
				em_t = '0;
				em_w = '0;
			end else begin
				em_t = comp_rd_q;
				em_w = comp_rd_q - CLK_W'(em_burst);
			end
		end else begin
			em_w = clock_q;
			em_t = clock_q + CLK_W'(em_burst);
		end
	end

	always_comb begin
		rec_we    = 1'b0;
		rec_waddr = i_q[AW-1:0];
		rec_wdata = bestrec_q;
		rec_re    = 1'b0;
		rec_raddr = i_q[AW-1:0];
		rem_we    = 1'b0;
		rem_wdata = rec_rd_q[BURST_BITS-1:0];
		comp_we   = 1'b0;
		case (cmd.op)
			pse_pkg::OP_LOAD: begin
				rec_we    = load_ok;
				rec_waddr = cnt_q[AW-1:0];
				rec_wdata = {cnt_q + 1'b1, priority_level, BURST_BITS'(burst_time)};
			end
			pse_pkg::OP_SW1: begin
				rec_we    = 1'b1;
				rec_waddr = best_q;
				rec_wdata = reci_q;
			end
			pse_pkg::OP_SW2: begin
				rec_we = 1'b1;
			end
			pse_pkg::OP_SI_RD, pse_pkg::OP_RI_RD: begin
				rec_re = 1'b1;
			end
			pse_pkg::OP_SJ_RD: begin
				rec_re    = 1'b1;
				rec_raddr = j_q[AW-1:0];
			end
			pse_pkg::OP_EM_RD: begin
				rec_re    = 1'b1;
				rec_raddr = k_q[AW-1:0];
			end
			pse_pkg::OP_RI_WR: begin
				rem_we = 1'b1;
			end
			pse_pkg::OP_RR_EX: begin
				rem_we    = r_cur != '0;
				rem_wdata = r_gt_q ? BURST_BITS'(QW'(r_cur) - q_eff) : '0;
				comp_we   = (r_cur != '0) && !r_gt_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		if (rec_re) begin
			rec_rd_q <= rec_mem[rec_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[i_q[AW-1:0]] <= rem_wdata;
		end
		if (cmd.op == pse_pkg::OP_RR_RD) begin
			rem_rd_q <= rem_mem[i_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (comp_we) begin
			comp_mem[i_q[AW-1:0]] <= rr_clock_nxt;
		end
		if (cmd.op == pse_pkg::OP_EM_RD) begin
			comp_rd_q <= comp_mem[k_q[AW-1:0]];
		end
	end

	// configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= pse_pkg::MODE_FCFS;
			quant_q <= pse_pkg::QUANT_W'(1);
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en && cfg_addr == pse_pkg::REG_SCHED_MODE) begin
				mode_q <= pse_pkg::mode_t'(cfg_wdata[1:0]);
			end
			if (cfg_wr_en && cfg_addr == pse_pkg::REG_TIME_QUANTUM) begin
				quant_q <= cfg_wdata[pse_pkg::QUANT_W-1:0];
			end
			if (cmd.op == pse_pkg::OP_LOAD && load_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.op == pse_pkg::OP_OUT) begin
				cnt_q <= '0;
			end
			valid_q <= (cmd.op == pse_pkg::OP_OUT) ||
			           (cmd.op == pse_pkg::OP_EM_EX && !status.k_last);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			pse_pkg::OP_INIT: begin
				clock_q <= '0;
				wsum_q  <= '0;
				tsum_q  <= '0;
				i_q     <= '0;
				k_q     <= '0;
				any_q   <= 1'b0;
			end
			pse_pkg::OP_SI_CAP: begin
				reci_q    <= rec_rd_q;
				bestrec_q <= rec_rd_q;
				best_q    <= i_q[AW-1:0];
				j_q       <= i_q + 1'b1;
			end
			pse_pkg::OP_SJ_CMP: begin
				if (key_new < key_best) begin
					best_q    <= j_q[AW-1:0];
					bestrec_q <= rec_rd_q;
				end
				j_q <= j_q + 1'b1;
			end
			pse_pkg::OP_SW2: begin
				i_q <= i_q + 1'b1;
			end
			pse_pkg::OP_RI_WR: begin
				i_q <= status.i_end ? '0 : i_q + 1'b1;
			end
			pse_pkg::OP_RR_EX: begin
				if (r_cur != '0) begin
					clock_q <= rr_clock_nxt;
				end
				i_q   <= status.i_end ? '0 : i_q + 1'b1;
				any_q <= status.i_end ? 1'b0 : (any_q | (r_cur != '0));
			end
			pse_pkg::OP_EM_EX: begin
				if (mode_q != pse_pkg::MODE_RR) begin
					clock_q <= em_t;
				end
				wsum_q <= wsum_q + SUM_W'(em_w);
				tsum_q <= tsum_q + SUM_W'(em_t);
				k_q    <= k_q + 1'b1;
				pnum_q <= pse_pkg::PNUM_W'(rec_rd_q[BURST_BITS+PW +: CNT_W]);
				wt_q   <= pse_pkg::TIME_W'(em_w);
				tt_q   <= pse_pkg::TIME_W'(em_t);
				aw_q   <= '0;
				at_q   <= '0;
				last_q <= 1'b0;
			end
			pse_pkg::OP_DIVW_WAIT: begin
				if (div_done) begin
					aw_q <= pse_pkg::AVG_W'(div_quo);
				end
			end
			pse_pkg::OP_DIVT_WAIT: begin
				if (div_done) begin
					at_q <= pse_pkg::AVG_W'(div_quo);
				end
			end
			pse_pkg::OP_OUT: begin
				last_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign div_go       = (cmd.op == pse_pkg::OP_DIVW_GO) || (cmd.op == pse_pkg::OP_DIVT_GO);
	assign div_dividend = (cmd.op == pse_pkg::OP_DIVT_GO)
	                      ? {tsum_q, pse_pkg::FRAC_BITS'(0)}
	                      : {wsum_q, pse_pkg::FRAC_BITS'(0)};

	pse_div #(
		.DVW(DVW),
		.DSW(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend(div_dividend),
		.divisor (cnt_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		status.mode     = mode_q;
		status.n_ge2    = cnt_q >= CNT_W'(2);
		status.j_last   = (CNT_W+1)'(j_q) + 1'b1 == (CNT_W+1)'(cnt_q);
		status.i_last   = (CNT_W+1)'(i_q) + (CNT_W+1)'(2) >= (CNT_W+1)'(cnt_q);
		status.i_end    = (CNT_W+1)'(i_q) + 1'b1 == (CNT_W+1)'(cnt_q);
		status.rr_more  = any_q | (r_cur != '0);
		status.k_last   = (CNT_W+1)'(k_q) + 1'b1 == (CNT_W+1)'(cnt_q);
		status.div_done = div_done;
	end

	assign result_valid      = valid_q;
	assign process_number    = pnum_q;
	assign waiting_time      = wt_q;
	assign turnaround_time   = tt_q;
	assign avg_waiting_fx    = aw_q;
	assign avg_turnaround_fx = at_q;
	assign last_result       = last_q;

endmodule
`default_nettype wire

@@ rtl/pse_ctrl.sv @@
// process schedule evaluator: sequencing state machine
// depends on pse_pkg; drives the datapath through cmd_t and reads status_t
`timescale 1ns / 1ps
`default_nettype none
module pse_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             last_process,
	input  wire pse_pkg::status_t status,
	output pse_pkg::cmd_t         cmd,
	output logic                  busy
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_SI_RD,
		ST_SI_CAP,
		ST_SJ_RD,
		ST_SJ_CMP,
		ST_SW1,
		ST_SW2,
		ST_RI_RD,
		ST_RI_WR,
		ST_RR_RD,
		ST_RR_EX,
		ST_EM_RD,
		ST_EM_EX,
		ST_DIVW_GO,
		ST_DIVW_WAIT,
		ST_DIVT_GO,
		ST_DIVT_WAIT,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_comb begin
		case (state_q)
			ST_IDLE:      cmd.op = accept ? pse_pkg::OP_LOAD : pse_pkg::OP_NONE;
			ST_START:     cmd.op = pse_pkg::OP_INIT;
			ST_SI_RD:     cmd.op = pse_pkg::OP_SI_RD;
			ST_SI_CAP:    cmd.op = pse_pkg::OP_SI_CAP;
			ST_SJ_RD:     cmd.op = pse_pkg::OP_SJ_RD;
			ST_SJ_CMP:    cmd.op = pse_pkg::OP_SJ_CMP;
			ST_SW1:       cmd.op = pse_pkg::OP_SW1;
			ST_SW2:       cmd.op = pse_pkg::OP_SW2;
			ST_RI_RD:     cmd.op = pse_pkg::OP_RI_RD;
			ST_RI_WR:     cmd.op = pse_pkg::OP_RI_WR;
			ST_RR_RD:     cmd.op = pse_pkg::OP_RR_RD;
			ST_RR_EX:     cmd.op = pse_pkg::OP_RR_EX;
			ST_EM_RD:     cmd.op = pse_pkg::OP_EM_RD;
			ST_EM_EX:     cmd.op = pse_pkg::OP_EM_EX;
			ST_DIVW_GO:   cmd.op = pse_pkg::OP_DIVW_GO;
			ST_DIVW_WAIT: cmd.op = pse_pkg::OP_DIVW_WAIT;
			ST_DIVT_GO:   cmd.op = pse_pkg::OP_DIVT_GO;
			ST_DIVT_WAIT: cmd.op = pse_pkg::OP_DIVT_WAIT;
			ST_OUT:       cmd.op = pse_pkg::OP_OUT;
			default:      cmd.op = pse_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			busy_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (accept && last_process) begin
						state_q <= ST_START;
					end else begin
						busy_q <= 1'b0;
					end
				end
				ST_START: begin
					if (status.mode == pse_pkg::MODE_RR) begin
						state_q <= ST_RI_RD;
					end else if (status.mode != pse_pkg::MODE_FCFS && status.n_ge2) begin
						state_q <= ST_SI_RD;
					end else begin
						state_q <= ST_EM_RD;
					end
				end
				ST_SI_RD:  state_q <= ST_SI_CAP;
				ST_SI_CAP: state_q <= ST_SJ_RD;
				ST_SJ_RD:  state_q <= ST_SJ_CMP;
				ST_SJ_CMP: state_q <= status.j_last ? ST_SW1 : ST_SJ_RD;
				ST_SW1:    state_q <= ST_SW2;
				ST_SW2:    state_q <= status.i_last ? ST_EM_RD : ST_SI_RD;
				ST_RI_RD:  state_q <= ST_RI_WR;
				ST_RI_WR:  state_q <= status.i_end ? ST_RR_RD : ST_RI_RD;
				ST_RR_RD:  state_q <= ST_RR_EX;
				ST_RR_EX: begin
					if (status.i_end && !status.rr_more) begin
						state_q <= ST_EM_RD;
					end else begin
						state_q <= ST_RR_RD;
					end
				end
				ST_EM_RD:  state_q <= ST_EM_EX;
				ST_EM_EX:  state_q <= status.k_last ? ST_DIVW_GO : ST_EM_RD;
				ST_DIVW_GO:   state_q <= ST_DIVW_WAIT;
				ST_DIVW_WAIT: state_q <= status.div_done ? ST_DIVT_GO : ST_DIVW_WAIT;
				ST_DIVT_GO:   state_q <= ST_DIVT_WAIT;
				ST_DIVT_WAIT: state_q <= status.div_done ? ST_OUT : ST_DIVT_WAIT;
				ST_OUT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/process_schedule_evaluator_unit.sv @@
// process schedule evaluator: top level joining controller and datapath
// depends on pse_pkg, pse_ctrl, pse_dp (and pse_div below it)
// loading: one process per cycle while busy is low; the last one raises busy
// after the last process: a setup step, then the sort (a read and a compare per pair,
//   a swap per pass), round robin fill, then rounds plus one empty closing round,
//   emission (a read and an update per result), then two shared-divider runs
//   and the final result
// results come out as single-cycle strobes; the receiver cannot stall them
// reset clears the process count, control state, mode to first come and quantum to 1; memories keep junk
`timescale 1ns / 1ps
`default_nettype none
module process_schedule_evaluator_unit #(
	parameter int MAX_PROCS  = 64,
	parameter int BURST_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration writes
	input  wire logic                           cfg_wr_en,
	input  wire logic                           cfg_addr,
	input  wire logic [pse_pkg::CFG_DW-1:0]     cfg_wdata,
	// process transfer
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [pse_pkg::BURST_IN_W-1:0] burst_time,
	input  wire logic [pse_pkg::PRI_W-1:0]      priority_level,
	input  wire logic                           last_process,
	// result transfer
	output logic                                result_valid,
	output logic [pse_pkg::PNUM_W-1:0]          process_number,
	output logic [pse_pkg::TIME_W-1:0]          waiting_time,
	output logic [pse_pkg::TIME_W-1:0]          turnaround_time,
	output logic [pse_pkg::AVG_W-1:0]           avg_waiting_fx,
	output logic [pse_pkg::AVG_W-1:0]           avg_turnaround_fx,
	output logic                                last_result
);

	// command and status between the sequencer and the datapath
	pse_pkg::cmd_t    cmd;
	pse_pkg::status_t status;

	pse_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_process(last_process),
		.status      (status),
		.cmd         (cmd),
		.busy        (busy)
	);

	// memories, sort and round robin walk, sums and divider live here
	pse_dp #(
		.MAX_PROCS (MAX_PROCS),
		.BURST_BITS(BURST_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.burst_time       (burst_time),
		.priority_level   (priority_level),
		.cmd              (cmd),
		.status           (status),
		.result_valid     (result_valid),
		.process_number   (process_number),
		.waiting_time     (waiting_time),
		.turnaround_time  (turnaround_time),
		.avg_waiting_fx   (avg_waiting_fx),
		.avg_turnaround_fx(avg_turnaround_fx),
		.last_result      (last_result)
	);

	// the final transfer of a set is followed by a quiet cycle
	a_last_then_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |=> !result_valid)
		else $error("result right after final result");

	// a last process always starts an evaluation
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_process |=> busy)
		else $error("evaluation did not start");

	// evaluation ends exactly with the final result
	a_end_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && last_result)
		else $error("busy dropped without final result");

	// averages only on the final result
	a_avg_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |-> avg_waiting_fx == '0 && avg_turnaround_fx == '0)
		else $error("average on non-final result");

endmodule
`default_nettype wire

@@ bench/process_schedule_evaluator_unit_test.sv @@
// process schedule evaluator testbench: directed and random process sets in every mode
// predicts per-process waiting/turnaround times and averages; needs pse_pkg and the unit
`timescale 1ns / 1ps
module process_schedule_evaluator_unit_test;

	localparam int CAPACITY     = 64;
	localparam int LIMIT        = 4000000;
	localparam int TAIL_WAIT    = 40;
	localparam int RANDOM_ITEMS = 76;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_wr_en;
	logic                               cfg_addr;
	logic [pse_pkg::CFG_DW-1:0]         cfg_wdata;
	logic                               start;
	logic                               busy;
	logic [pse_pkg::BURST_IN_W-1:0]     burst_time;
	logic [pse_pkg::PRI_W-1:0]          priority_level;
	logic                               last_process;
	logic                               result_valid;
	logic [pse_pkg::PNUM_W-1:0]         process_number;
	logic [pse_pkg::TIME_W-1:0]         waiting_time;
	logic [pse_pkg::TIME_W-1:0]         turnaround_time;
	logic [pse_pkg::AVG_W-1:0]          avg_waiting_fx;
	logic [pse_pkg::AVG_W-1:0]          avg_turnaround_fx;
	logic                               last_result;

	process_schedule_evaluator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy),
		.burst_time(burst_time), .priority_level(priority_level),
		.last_process(last_process),
		.result_valid(result_valid), .process_number(process_number),
		.waiting_time(waiting_time), .turnaround_time(turnaround_time),
		.avg_waiting_fx(avg_waiting_fx), .avg_turnaround_fx(avg_turnaround_fx),
		.last_result(last_result)
	);

	// one expected per-process report
	typedef struct {
		logic [pse_pkg::PNUM_W-1:0] num;
		logic [pse_pkg::TIME_W-1:0] wait_t;
		logic [pse_pkg::TIME_W-1:0] turn_t;
		logic [pse_pkg::AVG_W-1:0]  avg_wait;
		logic [pse_pkg::AVG_W-1:0]  avg_turn;
		logic                       last;
	} report_t;

	report_t pending_reports[$];
	int      error_count;
	int      cycle_count;

	// predictor copy of the block's state and registers
	pse_pkg::mode_t  cur_mode;
	int unsigned     cur_quantum;
	int unsigned     proc_burst[CAPACITY];
	int unsigned     proc_prio[CAPACITY];
	int unsigned     proc_id[CAPACITY];
	longint unsigned proc_done[CAPACITY];
	int unsigned     proc_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle counter and run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("** process_schedule_evaluator_unit: FAILED **");
			$finish;
		end
	end

	// selection sort on burst or priority, first index wins ties, not stable
	task automatic sort_processes(input bit on_prio);
		int unsigned best, kj, kb, t;
		for (int i = 0; i + 1 < proc_count; i++) begin
			best = i;
			for (int j = i + 1; j < proc_count; j++) begin
				kj = on_prio ? proc_prio[j] : proc_burst[j];
				kb = on_prio ? proc_prio[best] : proc_burst[best];
				if (kj < kb)
					best = j;
			end
			t = proc_burst[best]; proc_burst[best] = proc_burst[i]; proc_burst[i] = t;
			t = proc_prio[best];  proc_prio[best]  = proc_prio[i];  proc_prio[i]  = t;
			t = proc_id[best];    proc_id[best]    = proc_id[i];    proc_id[i]    = t;
		end
	endtask

	// store one process; on the marked last one schedule the set and queue its reports
	task automatic schedule_process(input int unsigned b, input int unsigned p, input bit fin);
		int unsigned     q;
		int unsigned     left[CAPACITY];
		bit              running;
		longint unsigned clock_now, w, t, wsum, tsum;
		report_t         r;
		if (proc_count < CAPACITY) begin
			proc_burst[proc_count] = b;
			proc_prio[proc_count]  = p;
			proc_id[proc_count]    = proc_count + 1;
			proc_count++;
		end
		if (!fin)
			return;
		clock_now = 0;
		wsum = 0;
		tsum = 0;
		if (cur_mode == pse_pkg::MODE_SJF)
			sort_processes(1'b0);
		else if (cur_mode == pse_pkg::MODE_PRIO)
			sort_processes(1'b1);
		if (cur_mode == pse_pkg::MODE_RR) begin
			// zero quantum behaves as one
			q = (cur_quantum == 0) ? 1 : cur_quantum;
			for (int i = 0; i < proc_count; i++) begin
				left[i] = proc_burst[i];
				proc_done[i] = 0;
			end
			running = 1'b1;
			while (running) begin
				running = 1'b0;
				for (int i = 0; i < proc_count; i++) begin
					if (left[i] > 0) begin
						running = 1'b1;
						if (left[i] > q) begin
							clock_now += q;
							left[i] -= q;
						end else begin
							clock_now += left[i];
							left[i] = 0;
							proc_done[i] = clock_now;
						end
					end
				end
			end
		end
		for (int k = 0; k < proc_count; k++) begin
			if (cur_mode == pse_pkg::MODE_RR) begin
				t = proc_done[k];
				w = t - proc_burst[k];
				// a zero burst is never served: both times read zero
				if (proc_burst[k] == 0) begin
					t = 0;
					w = 0;
				end
			end else begin
				w = clock_now;
				clock_now += proc_burst[k];
				t = clock_now;
			end
			wsum += w;
			tsum += t;
			r.num      = pse_pkg::PNUM_W'(proc_id[k]);
			r.wait_t   = pse_pkg::TIME_W'(w);
			r.turn_t   = pse_pkg::TIME_W'(t);
			r.avg_wait = '0;
			r.avg_turn = '0;
			r.last     = 1'b0;
			if (k == proc_count - 1) begin
				r.avg_wait = pse_pkg::AVG_W'((wsum << pse_pkg::FRAC_BITS) / proc_count);
				r.avg_turn = pse_pkg::AVG_W'((tsum << pse_pkg::FRAC_BITS) / proc_count);
				r.last     = 1'b1;
			end
			pending_reports.push_back(r);
		end
		proc_count = 0;
	endtask

	// result checker: every strobe is compared with the oldest expected report
	always @(posedge clk) begin
		report_t e;
		if (arst_n && result_valid) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected result, process %0d", $time, process_number);
				error_count++;
			end else begin
				e = pending_reports.pop_front();
				if (process_number !== e.num) begin
					$display("%0t: process_number exp %0d got %0d", $time, e.num, process_number);
					error_count++;
				end
				if (waiting_time !== e.wait_t) begin
					$display("%0t: waiting_time exp %0d got %0d", $time, e.wait_t, waiting_time);
					error_count++;
				end
				if (turnaround_time !== e.turn_t) begin
					$display("%0t: turnaround_time exp %0d got %0d", $time, e.turn_t,
						turnaround_time);
					error_count++;
				end
				if (avg_waiting_fx !== e.avg_wait) begin
					$display("%0t: avg_waiting_fx exp %0d got %0d", $time, e.avg_wait,
						avg_waiting_fx);
					error_count++;
				end
				if (avg_turnaround_fx !== e.avg_turn) begin
					$display("%0t: avg_turnaround_fx exp %0d got %0d", $time, e.avg_turn,
						avg_turnaround_fx);
					error_count++;
				end
				if (last_result !== e.last) begin
					$display("%0t: last_result exp %0b got %0b", $time, e.last, last_result);
					error_count++;
				end
			end
		end
	end

	// mostly no gap, often a short one, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// one process transfer: start held until a rising edge sees busy low
	task automatic send_process(input int unsigned b, input int unsigned p, input bit fin);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start          = 1'b1;
		burst_time     = pse_pkg::BURST_IN_W'(b);
		priority_level = pse_pkg::PRI_W'(p);
		last_process   = fin;
		do @(posedge clk); while (busy);
		schedule_process(b, p, fin);
	endtask

	// register write, only while the block is idle
	task automatic write_reg(input logic idx, input int unsigned val);
		@(negedge clk);
		start     = 1'b0;
		cfg_wr_en = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = pse_pkg::CFG_DW'(val);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == pse_pkg::REG_SCHED_MODE)
			cur_mode = pse_pkg::mode_t'(val[1:0]);
		else
			cur_quantum = val[15:0];
	endtask

	// wait until every expected report has arrived and the block is quiet again
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
	endtask

	task automatic set_mode(input pse_pkg::mode_t m, input int unsigned q);
		write_reg(pse_pkg::REG_SCHED_MODE, m);
		write_reg(pse_pkg::REG_TIME_QUANTUM, q);
	endtask

	// short directed sets: field extremes, ties, single process, every mode
	task automatic test_directed();
		set_mode(pse_pkg::MODE_FCFS, 1);
		send_process(16'hFFFF, 8'hFF, 1'b0);
		send_process(0, 0, 1'b0);
		send_process(16'hFFFF, 8'h00, 1'b1);
		drain();
		// lone process
		send_process(7, 3, 1'b1);
		drain();
		// shortest job with tied bursts exercises the unstable swap
		set_mode(pse_pkg::MODE_SJF, 1);
		send_process(5, 9, 1'b0);
		send_process(5, 1, 1'b0);
		send_process(2, 4, 1'b0);
		send_process(0, 0, 1'b1);
		drain();
		// priority with ties and extremes
		set_mode(pse_pkg::MODE_PRIO, 1);
		send_process(10, 8'hFF, 1'b0);
		send_process(20, 0, 1'b0);
		send_process(30, 8'hFF, 1'b0);
		send_process(40, 0, 1'b1);
		drain();
		// round robin with zero quantum treated as one, zero burst never served
		set_mode(pse_pkg::MODE_RR, 0);
		send_process(3, 0, 1'b0);
		send_process(0, 0, 1'b0);
		send_process(5, 0, 1'b1);
		drain();
		// round robin with the largest quantum and full bursts
		set_mode(pse_pkg::MODE_RR, 16'hFFFF);
		send_process(16'hFFFF, 1, 1'b0);
		send_process(16'hFFFE, 2, 1'b0);
		send_process(1, 3, 1'b1);
		drain();
	endtask

	// processes beyond capacity are dropped, the last mark still evaluates
	task automatic test_capacity();
		set_mode(pse_pkg::MODE_SJF, 1);
		for (int i = 0; i < CAPACITY + 2; i++)
			send_process($urandom_range(0, 65535), $urandom_range(0, 255),
				i == CAPACITY + 1);
		drain();
	endtask

	// random sets in random modes; config changes only after a full drain
	task automatic test_random();
		int unsigned    sent, n, q, bmax;
		pse_pkg::mode_t m;
		sent = 0;
		m = cur_mode;
		q = cur_quantum;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 1)) begin
				drain();
				m = pse_pkg::mode_t'($urandom_range(0, 3));
				case ($urandom_range(0, 3))
					0: q = 1;
					1: q = 16'hFFFF;
					2: q = $urandom_range(1, 16);
					default: q = $urandom_range(1, 65535);
				endcase
				set_mode(m, q);
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			// keep round robin rounds bounded for small quanta
			bmax = (m == pse_pkg::MODE_RR && q < 1600) ? q * 40 : 65535;
			for (int i = 0; i < n; i++)
				send_process($urandom_range(0, bmax), $urandom_range(0, 255), i == n - 1);
			sent += n;
		end
		drain();
	endtask

	initial begin
		error_count    = 0;
		cycle_count    = 0;
		proc_count     = 0;
		cur_mode       = pse_pkg::MODE_FCFS;
		cur_quantum    = 1;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_addr       = pse_pkg::REG_SCHED_MODE;
		cfg_wdata      = '0;
		start          = 1'b0;
		burst_time     = '0;
		priority_level = '0;
		last_process   = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_capacity();
		test_random();
		if (error_count == 0)
			$display("** process_schedule_evaluator_unit: PASSED **");
		else
			$display("** process_schedule_evaluator_unit: FAILED **");
		$finish;
	end

endmodule
